/* sv/rmq_pkg.sv */
package rmq_pkg;

  localparam int DW = 16;
  localparam int FB = 14;

  localparam int TR_W = DW + 2;
  localparam int RAD_W = DW + 2;
  localparam int SQ_IN_W = RAD_W + FB + 2;
  localparam int PAIRS = (SQ_IN_W + 1) / 2;
  localparam int ROOT_W = PAIRS + 1;
  localparam int REM_W = PAIRS + 3;
  localparam int SQ_PER = 3;
  localparam int SQ_STAGES = (PAIRS + SQ_PER - 1) / SQ_PER;

  localparam int NUM_W = DW + 1;
  localparam int QB = DW - 1;
  localparam int DIVD_W = NUM_W + FB + 1;
  localparam int DV_PER = 3;
  localparam int DV_STAGES = (QB + DV_PER - 1) / DV_PER;
  localparam int DIV_LAT = DV_STAGES + 2;
  localparam int LANES = 3;

  localparam int QS_W = ((ROOT_W + 1 > DW) ? ROOT_W + 1 : DW) + 1;

  typedef logic signed [DW-1:0] data_t;

  localparam data_t DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam data_t DMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [TR_W-1:0] ONE = TR_W'(1) << FB;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    branch_t                      br;
    logic                         bad;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0][NUM_W-1:0]  mag;
  } side_t;

  typedef struct packed {
    logic              valid;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
    logic [RAD_W-1:0]  rad;
    side_t             side;
  } sq_t;

  typedef struct packed {
    logic              ovf;
    logic              neg;
    logic [ROOT_W-1:0] s;
    logic [ROOT_W-1:0] rem;
    logic [QB-1:0]     low;
    logic [QB-1:0]     q;
  } dv_t;

  typedef struct packed {
    logic    valid;
    branch_t br;
    logic    bad;
    data_t   quarter;
  } ctrl_t;

  typedef struct packed {
    data_t   w;
    data_t   x;
    data_t   y;
    data_t   z;
    branch_t br;
    logic    bad;
  } res_t;

endpackage

/* sv/rotation_matrix_to_quaternion.sv */
// Converts one 3x3 rotation matrix of signed Q2.14 entries into a Q2.14 quaternion by
// Shepperd's method, one transaction per clock while in_stall is low. The branch is picked from the
// trace and the largest diagonal entry, a pipelined square-root unit (three result bits per
// stage) forms S, and three pipelined dividers (three quotient bits per stage) produce the
// other components in parallel. An accepted input passes through the front stage, the square-root
// stages, the divider stages and the output register on its way to the result. The output register
// has a one-entry skid behind it, so in_stall rises in the cycle after out_stall holds a waiting
// result and another result arrives. A non-positive radicand yields zero components with bad_input
// set; all components saturate.
module rotation_matrix_to_quaternion (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rmq_pkg::data_t  m00,
  input  rmq_pkg::data_t  m01,
  input  rmq_pkg::data_t  m02,
  input  rmq_pkg::data_t  m10,
  input  rmq_pkg::data_t  m11,
  input  rmq_pkg::data_t  m12,
  input  rmq_pkg::data_t  m20,
  input  rmq_pkg::data_t  m21,
  input  rmq_pkg::data_t  m22,
  output logic            out_valid,
  input  logic            out_stall,
  output rmq_pkg::data_t  qw,
  output rmq_pkg::data_t  qx,
  output rmq_pkg::data_t  qy,
  output rmq_pkg::data_t  qz,
  output logic [1:0]      branch_taken,
  output logic            bad_input
);
  import rmq_pkg::*;

  logic en;
  logic fr_valid;
  logic [RAD_W-1:0] fr_rad;
  side_t fr_side;
  logic sq_valid;
  logic [ROOT_W-1:0] sq_s;
  side_t sq_side;
  logic [QS_W-1:0] qsum;
  data_t quarter;
  data_t lane_q [LANES];
  ctrl_t dl [DIV_LAT];
  ctrl_t tail;
  res_t res_c, ob, sk;
  logic skid_valid;

  assign en = !skid_valid;
  assign in_stall = skid_valid;

  rmq_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .m00(m00), .m01(m01), .m02(m02),
    .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .out_valid(fr_valid), .rad(fr_rad), .side(fr_side)
  );

  rmq_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(fr_valid),
    .rad(fr_rad), .side(fr_side),
    .out_valid(sq_valid), .s(sq_s), .side_o(sq_side)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    rmq_div u_div (
      .clk(clk), .en(en),
      .mag(sq_side.mag[l]), .neg(sq_side.neg[l]), .s(sq_s),
      .q(lane_q[l])
    );
  end

  always_comb begin
    qsum = (QS_W'(sq_s) + QS_W'(2)) >> 2;
    quarter = (qsum > QS_W'(DMAX)) ? DMAX : DW'(qsum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dl[i].valid <= 1'b0;
      end
    end else if (en) begin
      dl[0] <= '{valid: sq_valid, br: sq_side.br, bad: sq_side.bad, quarter: quarter};
      for (int i = 1; i < DIV_LAT; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  assign tail = dl[DIV_LAT-1];

  always_comb begin
    res_c.br = tail.br;
    res_c.bad = tail.bad;
    case (tail.br)
      BR_TRACE: begin
        res_c.w = tail.quarter; res_c.x = lane_q[0]; res_c.y = lane_q[1]; res_c.z = lane_q[2];
      end
      BR_X: begin
        res_c.w = lane_q[0]; res_c.x = tail.quarter; res_c.y = lane_q[1]; res_c.z = lane_q[2];
      end
      BR_Y: begin
        res_c.w = lane_q[0]; res_c.x = lane_q[1]; res_c.y = tail.quarter; res_c.z = lane_q[2];
      end
      default: begin
        res_c.w = lane_q[0]; res_c.x = lane_q[1]; res_c.y = lane_q[2]; res_c.z = tail.quarter;
      end
    endcase
    if (tail.bad) begin
      res_c.w = '0;
      res_c.x = '0;
      res_c.y = '0;
      res_c.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= tail.valid;
      end
    end else if (tail.valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      ob <= skid_valid ? sk : res_c;
    end else if (en) begin
      sk <= res_c;
    end
  end

  assign qw = ob.w;
  assign qx = ob.x;
  assign qy = ob.y;
  assign qz = ob.z;
  assign branch_taken = ob.br;
  assign bad_input = ob.bad;

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a pending output");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> !skid_valid)
    else $error("skid entry not drained");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_input) |-> (qw == '0 && qx == '0 && qy == '0 && qz == '0))
    else $error("bad input result is not zero");

  a_trace_w_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !bad_input && branch_taken == BR_TRACE) |-> !qw[DW-1])
    else $error("scalar part negative in trace branch");

endmodule

/* sv/rmq_front.sv */
module rmq_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  rmq_pkg::data_t             m00,
  input  rmq_pkg::data_t             m01,
  input  rmq_pkg::data_t             m02,
  input  rmq_pkg::data_t             m10,
  input  rmq_pkg::data_t             m11,
  input  rmq_pkg::data_t             m12,
  input  rmq_pkg::data_t             m20,
  input  rmq_pkg::data_t             m21,
  input  rmq_pkg::data_t             m22,
  output logic                       out_valid,
  output logic [rmq_pkg::RAD_W-1:0]  rad,
  output rmq_pkg::side_t             side
);
  import rmq_pkg::*;

  logic signed [TR_W-1:0] a00, a11, a22, tr, rad_c;
  logic signed [NUM_W-1:0] d21m12, d02m20, d10m01, s01p10, s02p20, s12p21;
  logic signed [NUM_W-1:0] n [LANES];
  branch_t br_c;
  side_t side_c;

  always_comb begin
    a00 = TR_W'(m00);
    a11 = TR_W'(m11);
    a22 = TR_W'(m22);
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      br_c = BR_TRACE;
      rad_c = tr + ONE;
    end else if (a00 > a11 && a00 > a22) begin
      br_c = BR_X;
      rad_c = ONE + a00 - a11 - a22;
    end else if (a11 > a22) begin
      br_c = BR_Y;
      rad_c = ONE + a11 - a00 - a22;
    end else begin
      br_c = BR_Z;
      rad_c = ONE + a22 - a00 - a11;
    end

    d21m12 = NUM_W'(m21) - NUM_W'(m12);
    d02m20 = NUM_W'(m02) - NUM_W'(m20);
    d10m01 = NUM_W'(m10) - NUM_W'(m01);
    s01p10 = NUM_W'(m01) + NUM_W'(m10);
    s02p20 = NUM_W'(m02) + NUM_W'(m20);
    s12p21 = NUM_W'(m12) + NUM_W'(m21);

    case (br_c)
      BR_TRACE: begin
        n[0] = d21m12; n[1] = d02m20; n[2] = d10m01;
      end
      BR_X: begin
        n[0] = d21m12; n[1] = s01p10; n[2] = s02p20;
      end
      BR_Y: begin
        n[0] = d02m20; n[1] = s01p10; n[2] = s12p21;
      end
      default: begin
        n[0] = d10m01; n[1] = s02p20; n[2] = s12p21;
      end
    endcase

    side_c.br = br_c;
    side_c.bad = (rad_c <= 0);
    for (int i = 0; i < LANES; i++) begin
      side_c.neg[i] = n[i][NUM_W-1];
      side_c.mag[i] = n[i][NUM_W-1] ? NUM_W'(-n[i]) : NUM_W'(n[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad <= RAD_W'(rad_c);
      side <= side_c;
    end
  end

endmodule

/* sv/rmq_sqrt.sv */
module rmq_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rmq_pkg::RAD_W-1:0]   rad,
  input  rmq_pkg::side_t              side,
  output logic                        out_valid,
  output logic [rmq_pkg::ROOT_W-1:0]  s,
  output rmq_pkg::side_t              side_o
);
  import rmq_pkg::*;

  function automatic sq_t sq_step(sq_t cur, int idx);
    logic [2*PAIRS-1:0] x;
    logic [1:0] pr;
    logic [REM_W-1:0] r, trial;
    sq_t nx;
    nx = cur;
    x = (2*PAIRS)'(cur.rad) << (FB + 2);
    pr = x[2*idx +: 2];
    r = (cur.rem << 2) | REM_W'(pr);
    trial = (REM_W'(cur.root) << 2) | REM_W'(1);
    if (r >= trial) begin
      nx.rem = r - trial;
      nx.root = (cur.root << 1) | ROOT_W'(1);
    end else begin
      nx.rem = r;
      nx.root = cur.root << 1;
    end
    return nx;
  endfunction

  sq_t st_in;
  sq_t prv [SQ_STAGES];
  sq_t nxt [SQ_STAGES];
  sq_t st  [SQ_STAGES];
  sq_t last;

  assign st_in = '{valid: in_valid, root: '0, rem: '0, rad: rad, side: side};
  assign last = st[SQ_STAGES-1];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign prv[k] = st_in;
    end else begin : g_rest
      assign prv[k] = st[k-1];
    end

    always_comb begin
      sq_t cur;
      int idx;
      cur = prv[k];
      for (int j = 0; j < SQ_PER; j++) begin
        idx = PAIRS - 1 - (k * SQ_PER + j);
        if (idx >= 0) begin
          cur = sq_step(cur, idx);
        end
      end
      nxt[k] = cur;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[k].valid <= 1'b0;
      end else if (en) begin
        st[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s <= (last.rem > REM_W'(last.root)) ? ROOT_W'(last.root + ROOT_W'(1)) : last.root;
      side_o <= last.side;
    end
  end

endmodule

/* sv/rmq_div.sv */
module rmq_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rmq_pkg::NUM_W-1:0]   mag,
  input  logic                        neg,
  input  logic [rmq_pkg::ROOT_W-1:0]  s,
  output rmq_pkg::data_t              q
);
  import rmq_pkg::*;

  logic [DIVD_W-1:0] dvd, hi;
  dv_t st0_c, st0;
  dv_t prv [DV_STAGES];
  dv_t nxt [DV_STAGES];
  dv_t st  [DV_STAGES];
  dv_t last;
  data_t qv, res_c;

  always_comb begin
    dvd = (DIVD_W'(mag) << FB) + DIVD_W'(s >> 1);
    hi = dvd >> QB;
    st0_c.ovf = (hi >= DIVD_W'(s));
    st0_c.neg = neg;
    st0_c.s = s;
    st0_c.rem = hi[ROOT_W-1:0];
    st0_c.low = dvd[QB-1:0];
    st0_c.q = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st0 <= st0_c;
    end
  end

  for (genvar k = 0; k < DV_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign prv[k] = st0;
    end else begin : g_rest
      assign prv[k] = st[k-1];
    end

    always_comb begin
      dv_t cur;
      logic [ROOT_W:0] r;
      int idx;
      cur = prv[k];
      for (int j = 0; j < DV_PER; j++) begin
        idx = QB - 1 - (k * DV_PER + j);
        if (idx >= 0) begin
          r = {cur.rem, cur.low[idx]};
          if (r >= {1'b0, cur.s}) begin
            r = r - {1'b0, cur.s};
            cur.q[idx] = 1'b1;
          end
          cur.rem = r[ROOT_W-1:0];
        end
      end
      nxt[k] = cur;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign last = st[DV_STAGES-1];

  always_comb begin
    qv = data_t'({1'b0, last.q});
    if (last.ovf) begin
      res_c = last.neg ? DMIN : DMAX;
    end else begin
      res_c = last.neg ? -qv : qv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= res_c;
    end
  end

endmodule
